@@ hdl/bdm_pkg.sv @@
`timescale 1ns / 1ps
// Package for the battery derating monitor: field widths, limits, reset values
// of the threshold registers and the register index codes. No dependencies.
package bdm_pkg;

  localparam int MAX_SENSORS        = 4;
  localparam int NOMINAL_CURRENT_MA = 20000;
  localparam int SPREAD_LIMIT_MV    = 100;
  localparam int VOLT_RES_MV        = 1;
  localparam int TEMP_RES_DC        = 10;
  localparam int MAX_MISSING        = 1;

  localparam int VOLT_W  = 13;
  localparam int TEMP_W  = 12;
  localparam int SUM_W   = 16;
  localparam int LIM_W   = 15;
  localparam int FACT_W  = 17;
  localparam int SEEN_W  = $clog2(MAX_SENSORS + 1);
  localparam int RAMP_W  = 15;
  localparam int DIV_W   = 14;
  localparam int QUO_W   = 16;
  localparam int STEP_W  = $clog2(QUO_W);
  localparam int PROD_W  = 2 * FACT_W;
  localparam int IDX_W   = 3;

  localparam logic [FACT_W-1:0] Q_ONE     = FACT_W'(65536);
  localparam logic [LIM_W-1:0]  LIMIT_MAX = {LIM_W{1'b1}};

  localparam logic [IDX_W-1:0] CFG_VOLT_CRIT_HIGH = 3'd0;
  localparam logic [IDX_W-1:0] CFG_VOLT_WARN_HIGH = 3'd1;
  localparam logic [IDX_W-1:0] CFG_VOLT_WARN_LOW  = 3'd2;
  localparam logic [IDX_W-1:0] CFG_VOLT_CRIT_LOW  = 3'd3;
  localparam logic [IDX_W-1:0] CFG_TEMP_CRIT_HIGH = 3'd4;
  localparam logic [IDX_W-1:0] CFG_TEMP_WARN_HIGH = 3'd5;
  localparam logic [IDX_W-1:0] CFG_TEMP_WARN_LOW  = 3'd6;
  localparam logic [IDX_W-1:0] CFG_TEMP_CRIT_LOW  = 3'd7;

  localparam logic [VOLT_W-1:0]        VOLT_CRIT_HIGH_RST = 13'd4150;
  localparam logic [VOLT_W-1:0]        VOLT_WARN_HIGH_RST = 13'd4100;
  localparam logic [VOLT_W-1:0]        VOLT_WARN_LOW_RST  = 13'd3300;
  localparam logic [VOLT_W-1:0]        VOLT_CRIT_LOW_RST  = 13'd3000;
  localparam logic signed [TEMP_W-1:0] TEMP_CRIT_HIGH_RST = 12'sd500;
  localparam logic signed [TEMP_W-1:0] TEMP_WARN_HIGH_RST = 12'sd400;
  localparam logic signed [TEMP_W-1:0] TEMP_WARN_LOW_RST  = 12'sd50;
  localparam logic signed [TEMP_W-1:0] TEMP_CRIT_LOW_RST  = 12'sd20;

  typedef struct packed {
    logic                     pad;
    logic                     sensor_present;
    logic signed [TEMP_W-1:0] sensor_temp;
    logic [VOLT_W-1:0]        cell_max_mv;
    logic [VOLT_W-1:0]        cell_min_mv;
  } in_data_t;

  typedef struct packed {
    logic                     pad;
    logic                     average_valid;
    logic signed [TEMP_W-1:0] average_temp;
    logic [LIM_W-1:0]         discharge_limit_ma;
    logic [LIM_W-1:0]         charge_limit_ma;
    logic                     safe_changed;
    logic                     safe_to_operate;
    logic                     temperatures_ok;
    logic                     voltages_ok;
  } out_data_t;

endpackage

@@ hdl/battery_derating_monitor.sv @@
`timescale 1ns / 1ps
// m_axis_tvalid rises after a voltage transfer or a temperature transfer that closes its group.
// Each 16-step division runs on one shared restoring divider; two at most run.
// Four passes of one shared multiplier follow; one item is in work at a time, so a new transfer
// is taken only once the last result is registered, and a full output register holds the block.
// A temperature transfer that does not close its group gives no result.
// Reset is synchronous: thresholds return to defaults, flags, factors and the group clear.
module battery_derating_monitor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [39:0]                    s_axis_tdata,  // cell_min_mv, cell_max_mv, sensor_temp, sensor_present
  input  logic                           s_axis_tuser,  // req_type
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [47:0]                    m_axis_tdata,  // voltages_ok, temperatures_ok, safe_to_operate,
                                                        // safe_changed, charge_limit_ma,
                                                        // discharge_limit_ma, average_temp, average_valid
  output logic                           m_axis_tuser,  // source_kind
  input  logic                           cfg_we,
  input  logic [bdm_pkg::IDX_W-1:0]      cfg_index,
  input  logic [bdm_pkg::VOLT_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_DIV, ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_DONE
  } state_t;

  typedef enum logic [1:0] {JOB_CHG, JOB_DIS, JOB_TMP, JOB_AVG} job_t;

  state_t state;
  job_t   job;

  logic [bdm_pkg::VOLT_W-1:0]        volt_crit_high, volt_warn_high, volt_warn_low, volt_crit_low;
  logic signed [bdm_pkg::TEMP_W-1:0] temp_crit_high, temp_warn_high, temp_warn_low, temp_crit_low;

  logic [bdm_pkg::VOLT_W-1:0]        vmin, vmax;
  logic                              kind;
  logic                              volt_ok, temp_ok, safe_flag, avg_valid;
  logic [bdm_pkg::FACT_W-1:0]        charge_factor, discharge_factor, temp_factor;
  logic signed [bdm_pkg::TEMP_W-1:0] group_min, group_max, average;
  logic signed [bdm_pkg::SUM_W-1:0]  group_sum;
  logic [bdm_pkg::SEEN_W-1:0]        group_missing, group_seen;
  logic                              group_any;
  logic [bdm_pkg::LIM_W-1:0]         charge_ma;

  logic [bdm_pkg::DIV_W-1:0]         rem, divisor;
  logic [bdm_pkg::QUO_W-1:0]         quo;
  logic [bdm_pkg::STEP_W-1:0]        step;
  logic                              avg_neg;
  logic [bdm_pkg::PROD_W-1:0]        prod;

  bdm_pkg::in_data_t  din;
  bdm_pkg::out_data_t dout;
  logic                              accept;

  assign din           = bdm_pkg::in_data_t'(s_axis_tdata);
  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Input-side checks.
  logic                              volt_ok_in;
  logic signed [bdm_pkg::RAMP_W-1:0] spread;
  logic signed [bdm_pkg::TEMP_W-1:0] t_in;

  assign spread = $signed({2'b00, din.cell_max_mv}) - $signed({2'b00, din.cell_min_mv});
  assign volt_ok_in = (din.cell_max_mv < volt_crit_high) && (din.cell_min_mv > volt_crit_low)
                      && (spread < bdm_pkg::RAMP_W'(bdm_pkg::SPREAD_LIMIT_MV));
  assign t_in = din.sensor_temp;

  // Ramp selection for the current job.
  logic                              in_range;
  logic [bdm_pkg::SEEN_W-1:0]        missing_total, present_cnt;
  logic signed [bdm_pkg::RAMP_W-1:0] num, den;
  logic                              fixed;
  logic [bdm_pkg::FACT_W-1:0]        fixed_val;
  logic                              ramp_zero, ramp_sat, setup_direct;
  logic [bdm_pkg::FACT_W-1:0]        direct_val;
  logic [bdm_pkg::QUO_W-1:0]         sum_mag;

  assign in_range = group_any && (group_max < temp_crit_high) && (group_min > temp_crit_low);
  assign missing_total = group_missing + (bdm_pkg::SEEN_W'(bdm_pkg::MAX_SENSORS) - group_seen);
  assign present_cnt = group_seen - group_missing;
  assign sum_mag = group_sum[bdm_pkg::SUM_W-1] ? bdm_pkg::QUO_W'(-group_sum)
                                               : bdm_pkg::QUO_W'(group_sum);

  always_comb begin
    fixed     = 1'b0;
    fixed_val = '0;
    num       = '0;
    den       = '0;
    unique case (job)
      JOB_CHG: begin
        if (vmax > volt_crit_high) begin
          fixed = 1'b1;
        end else if (vmax >= volt_warn_high) begin
          num = $signed({2'b00, volt_crit_high}) - $signed({2'b00, vmax});
          den = $signed({2'b00, volt_crit_high}) - $signed({2'b00, volt_warn_high})
                + bdm_pkg::RAMP_W'(bdm_pkg::VOLT_RES_MV);
        end else begin
          fixed     = 1'b1;
          fixed_val = bdm_pkg::Q_ONE;
        end
      end
      JOB_DIS: begin
        if (vmin < volt_crit_low) begin
          fixed = 1'b1;
        end else if (vmin <= volt_warn_low) begin
          num = $signed({2'b00, vmin}) - $signed({2'b00, volt_crit_low});
          den = $signed({2'b00, volt_warn_low}) - $signed({2'b00, volt_crit_low})
                + bdm_pkg::RAMP_W'(bdm_pkg::VOLT_RES_MV);
        end else begin
          fixed     = 1'b1;
          fixed_val = bdm_pkg::Q_ONE;
        end
      end
      JOB_TMP: begin
        if (!in_range) begin
          fixed = 1'b1;
        end else if (group_max >= temp_warn_high) begin
          num = $signed({{3{temp_crit_high[11]}}, temp_crit_high})
                - $signed({{3{group_max[11]}}, group_max});
          den = $signed({{3{temp_crit_high[11]}}, temp_crit_high})
                - $signed({{3{temp_warn_high[11]}}, temp_warn_high})
                + bdm_pkg::RAMP_W'(bdm_pkg::TEMP_RES_DC);
        end else if (group_min <= temp_warn_low) begin
          num = $signed({{3{group_min[11]}}, group_min})
                - $signed({{3{temp_crit_low[11]}}, temp_crit_low});
          den = $signed({{3{temp_warn_low[11]}}, temp_warn_low})
                - $signed({{3{temp_crit_low[11]}}, temp_crit_low})
                + bdm_pkg::RAMP_W'(bdm_pkg::TEMP_RES_DC);
        end else begin
          fixed     = 1'b1;
          fixed_val = bdm_pkg::Q_ONE;
        end
      end
      default: begin
        fixed = 1'b1;
      end
    endcase
  end

  assign ramp_zero    = (den <= 0) || (num <= 0);
  assign ramp_sat     = (num >= den);
  assign setup_direct = fixed || ramp_zero || ramp_sat;
  assign direct_val   = fixed ? fixed_val : (ramp_zero ? '0 : bdm_pkg::Q_ONE);

  // Shared restoring divider step.
  logic [bdm_pkg::DIV_W:0]     trial;
  logic                        ge;
  logic [bdm_pkg::DIV_W-1:0]   rem_next;
  logic [bdm_pkg::QUO_W-1:0]   quo_next;
  logic [bdm_pkg::TEMP_W-1:0]  avg_mag;

  assign trial    = {rem, quo[bdm_pkg::QUO_W-1]};
  assign ge       = (trial >= {1'b0, divisor});
  assign rem_next = ge ? bdm_pkg::DIV_W'(trial - {1'b0, divisor}) : trial[bdm_pkg::DIV_W-1:0];
  assign quo_next = {quo[bdm_pkg::QUO_W-2:0], ge};
  assign avg_mag  = quo_next[bdm_pkg::TEMP_W-1:0];

  // Shared multiplier.
  logic [bdm_pkg::FACT_W-1:0] mul_a, mul_b;
  logic [bdm_pkg::LIM_W-1:0]  lim_sat;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MUL0: begin
        mul_a = charge_factor;
        mul_b = temp_factor;
      end
      ST_MUL2: begin
        mul_a = discharge_factor;
        mul_b = temp_factor;
      end
      ST_MUL1, ST_MUL3: begin
        mul_a = prod[32:16];
        mul_b = bdm_pkg::FACT_W'(bdm_pkg::NOMINAL_CURRENT_MA);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign lim_sat = (prod[bdm_pkg::PROD_W-1:16] > (bdm_pkg::PROD_W-16)'(bdm_pkg::LIMIT_MAX))
                   ? bdm_pkg::LIMIT_MAX : prod[16+bdm_pkg::LIM_W-1:16];

  always_comb begin
    dout                    = '0;
    dout.voltages_ok        = volt_ok;
    dout.temperatures_ok    = temp_ok;
    dout.safe_to_operate    = volt_ok && temp_ok;
    dout.safe_changed       = (volt_ok && temp_ok) != safe_flag;
    dout.charge_limit_ma    = charge_ma;
    dout.discharge_limit_ma = lim_sat;
    dout.average_temp       = average;
    dout.average_valid      = avg_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      job              <= JOB_CHG;
      m_axis_tvalid    <= 1'b0;
      volt_ok          <= 1'b0;
      temp_ok          <= 1'b0;
      safe_flag        <= 1'b0;
      charge_factor    <= '0;
      discharge_factor <= '0;
      temp_factor      <= '0;
      group_sum        <= '0;
      group_missing    <= '0;
      group_seen       <= '0;
      group_any        <= 1'b0;
      volt_crit_high   <= bdm_pkg::VOLT_CRIT_HIGH_RST;
      volt_warn_high   <= bdm_pkg::VOLT_WARN_HIGH_RST;
      volt_warn_low    <= bdm_pkg::VOLT_WARN_LOW_RST;
      volt_crit_low    <= bdm_pkg::VOLT_CRIT_LOW_RST;
      temp_crit_high   <= bdm_pkg::TEMP_CRIT_HIGH_RST;
      temp_warn_high   <= bdm_pkg::TEMP_WARN_HIGH_RST;
      temp_warn_low    <= bdm_pkg::TEMP_WARN_LOW_RST;
      temp_crit_low    <= bdm_pkg::TEMP_CRIT_LOW_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bdm_pkg::CFG_VOLT_CRIT_HIGH: volt_crit_high <= cfg_data;
          bdm_pkg::CFG_VOLT_WARN_HIGH: volt_warn_high <= cfg_data;
          bdm_pkg::CFG_VOLT_WARN_LOW:  volt_warn_low  <= cfg_data;
          bdm_pkg::CFG_VOLT_CRIT_LOW:  volt_crit_low  <= cfg_data;
          bdm_pkg::CFG_TEMP_CRIT_HIGH: temp_crit_high <= $signed(cfg_data[bdm_pkg::TEMP_W-1:0]);
          bdm_pkg::CFG_TEMP_WARN_HIGH: temp_warn_high <= $signed(cfg_data[bdm_pkg::TEMP_W-1:0]);
          bdm_pkg::CFG_TEMP_WARN_LOW:  temp_warn_low  <= $signed(cfg_data[bdm_pkg::TEMP_W-1:0]);
          default:                     temp_crit_low  <= $signed(cfg_data[bdm_pkg::TEMP_W-1:0]);
        endcase
      end

      if (m_axis_tvalid && m_axis_tready && (state != ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!s_axis_tuser) begin
              kind      <= 1'b0;
              vmin      <= din.cell_min_mv;
              vmax      <= din.cell_max_mv;
              volt_ok   <= volt_ok_in;
              avg_valid <= 1'b0;
              average   <= '0;
              job       <= JOB_CHG;
              state     <= ST_SETUP;
            end else begin
              if (group_seen < bdm_pkg::SEEN_W'(bdm_pkg::MAX_SENSORS)) begin
                group_seen <= group_seen + 1'b1;
                if (din.sensor_present) begin
                  if (!group_any || (t_in > group_max)) begin
                    group_max <= t_in;
                  end
                  if (!group_any || (t_in < group_min)) begin
                    group_min <= t_in;
                  end
                  group_any <= 1'b1;
                  group_sum <= group_sum + $signed({{4{t_in[11]}}, t_in});
                end else begin
                  group_missing <= group_missing + 1'b1;
                end
              end
              if (s_axis_tlast) begin
                kind  <= 1'b1;
                job   <= JOB_TMP;
                state <= ST_SETUP;
              end
            end
          end
        end
        ST_SETUP: begin
          if (job == JOB_AVG) begin
            if (group_any) begin
              rem     <= '0;
              quo     <= sum_mag;
              divisor <= bdm_pkg::DIV_W'(present_cnt);
              avg_neg <= group_sum[bdm_pkg::SUM_W-1];
              step    <= '1;
              state   <= ST_DIV;
            end else begin
              average       <= '0;
              group_sum     <= '0;
              group_missing <= '0;
              group_seen    <= '0;
              group_any     <= 1'b0;
              state         <= ST_MUL0;
            end
          end else begin
            if (job == JOB_TMP) begin
              temp_ok   <= in_range && (missing_total <= bdm_pkg::SEEN_W'(bdm_pkg::MAX_MISSING));
              avg_valid <= group_any;
            end
            if (setup_direct) begin
              unique case (job)
                JOB_CHG: begin
                  charge_factor <= direct_val;
                  job           <= JOB_DIS;
                end
                JOB_DIS: begin
                  discharge_factor <= direct_val;
                  state            <= ST_MUL0;
                end
                default: begin
                  temp_factor <= direct_val;
                  job         <= JOB_AVG;
                end
              endcase
            end else begin
              rem     <= num[bdm_pkg::DIV_W-1:0];
              quo     <= '0;
              divisor <= den[bdm_pkg::DIV_W-1:0];
              step    <= '1;
              state   <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          rem  <= rem_next;
          quo  <= quo_next;
          step <= step - 1'b1;
          if (step == '0) begin
            unique case (job)
              JOB_CHG: begin
                charge_factor <= {1'b0, quo_next};
                job           <= JOB_DIS;
                state         <= ST_SETUP;
              end
              JOB_DIS: begin
                discharge_factor <= {1'b0, quo_next};
                state            <= ST_MUL0;
              end
              JOB_TMP: begin
                temp_factor <= {1'b0, quo_next};
                job         <= JOB_AVG;
                state       <= ST_SETUP;
              end
              default: begin
                average       <= avg_neg ? -$signed(avg_mag) : $signed(avg_mag);
                group_sum     <= '0;
                group_missing <= '0;
                group_seen    <= '0;
                group_any     <= 1'b0;
                state         <= ST_MUL0;
              end
            endcase
          end
        end
        ST_MUL0: begin
          prod  <= mul_a * mul_b;
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          prod  <= mul_a * mul_b;
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          charge_ma <= lim_sat;
          prod      <= mul_a * mul_b;
          state     <= ST_MUL3;
        end
        ST_MUL3: begin
          prod  <= mul_a * mul_b;
          state <= ST_DONE;
        end
        default: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= dout;
            m_axis_tuser  <= kind;
            safe_flag     <= volt_ok && temp_ok;
            state         <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

@@ sim/battery_derating_monitor_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for battery_derating_monitor: directed corners, then random voltage
// transfers and sensor groups under several threshold settings, with random stalls on both sides.
// Depends on bdm_pkg and battery_derating_monitor.
module battery_derating_monitor_test;

  localparam bit KIND_VOLTAGE     = 1'b0;
  localparam bit KIND_TEMPERATURE = 1'b1;

  localparam int THR_ORDERED   = 0;
  localparam int THR_ALL_LOW   = 1;
  localparam int THR_ALL_HIGH  = 2;
  localparam int THR_SCRAMBLED = 3;

  localparam int RANDOM_ITEMS = 2000;
  localparam int PHASES       = 6;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 2000000;

  localparam int VOLT_MAX = 5000;
  localparam int TEMP_MIN = -400;
  localparam int TEMP_MAX = 1500;

  typedef struct {
    bit                 kind;
    bdm_pkg::out_data_t fields;
  } pack_result_t;

  logic                       clk           = 1'b0;
  logic                       rst           = 1'b1;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  bdm_pkg::in_data_t          s_axis_tdata  = '0;
  logic                       s_axis_tuser  = 1'b0;
  logic                       s_axis_tlast  = 1'b0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  bdm_pkg::out_data_t         m_axis_tdata;
  logic                       m_axis_tuser;
  logic                       cfg_we        = 1'b0;
  logic [bdm_pkg::IDX_W-1:0]  cfg_index     = '0;
  logic [bdm_pkg::VOLT_W-1:0] cfg_data      = '0;

  // Thresholds as the block holds them, indexed by register index.
  int thr [8];
  bit volt_ok_q, temp_ok_q, safe_q;
  int chg_volt_f, dis_volt_f, temp_f;
  int grp_min, grp_max, grp_sum, grp_missing, grp_seen;
  bit grp_any;

  pack_result_t pending_results[$];
  int err_count   = 0;
  int cycle_count = 0;
  int send_burst  = 0;
  bit hold_ready  = 1'b0;
  int hold_count  = 0;

  battery_derating_monitor uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side backpressure: short stalls, a few long ones, and long stall-free runs.
  always @(posedge clk) begin
    if (hold_count == 0) begin
      hold_ready = !hold_ready;
      if (hold_ready) begin
        hold_count = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 20);
      end else begin
        hold_count = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      end
    end
    hold_count--;
    m_axis_tready <= hold_ready;
  end

  function automatic void reset_model();
    thr[bdm_pkg::CFG_VOLT_CRIT_HIGH] = int'(bdm_pkg::VOLT_CRIT_HIGH_RST);
    thr[bdm_pkg::CFG_VOLT_WARN_HIGH] = int'(bdm_pkg::VOLT_WARN_HIGH_RST);
    thr[bdm_pkg::CFG_VOLT_WARN_LOW]  = int'(bdm_pkg::VOLT_WARN_LOW_RST);
    thr[bdm_pkg::CFG_VOLT_CRIT_LOW]  = int'(bdm_pkg::VOLT_CRIT_LOW_RST);
    thr[bdm_pkg::CFG_TEMP_CRIT_HIGH] = int'(bdm_pkg::TEMP_CRIT_HIGH_RST);
    thr[bdm_pkg::CFG_TEMP_WARN_HIGH] = int'(bdm_pkg::TEMP_WARN_HIGH_RST);
    thr[bdm_pkg::CFG_TEMP_WARN_LOW]  = int'(bdm_pkg::TEMP_WARN_LOW_RST);
    thr[bdm_pkg::CFG_TEMP_CRIT_LOW]  = int'(bdm_pkg::TEMP_CRIT_LOW_RST);
    volt_ok_q = 1'b0;
    temp_ok_q = 1'b0;
    safe_q = 1'b0;
    chg_volt_f = 0;
    dis_volt_f = 0;
    temp_f = 0;
    grp_min = 0;
    grp_max = 0;
    grp_sum = 0;
    grp_missing = 0;
    grp_seen = 0;
    grp_any = 1'b0;
  endfunction

  // Linear ramp in Q1.16; an empty or inverted ramp gives zero.
  function automatic int ramp_q16(int num, int den);
    longint q;
    if (den <= 0 || num <= 0) return 0;
    q = (longint'(num) << 16) / den;
    return (q > int'(bdm_pkg::Q_ONE)) ? int'(bdm_pkg::Q_ONE) : int'(q);
  endfunction

  function automatic logic [bdm_pkg::LIM_W-1:0] current_limit(int fv, int ft);
    longint p;
    p = (longint'(fv) * longint'(ft)) >> 16;
    p = (p * bdm_pkg::NOMINAL_CURRENT_MA) >> 16;
    if (p > bdm_pkg::LIMIT_MAX) return bdm_pkg::LIMIT_MAX;
    return p[bdm_pkg::LIM_W-1:0];
  endfunction

  function automatic void record_result(bit kind, int avg, bit avg_valid);
    pack_result_t r;
    bit safe_now;
    safe_now = volt_ok_q && temp_ok_q;
    r.kind = kind;
    r.fields = '0;
    r.fields.voltages_ok = volt_ok_q;
    r.fields.temperatures_ok = temp_ok_q;
    r.fields.safe_to_operate = safe_now;
    r.fields.safe_changed = (safe_now != safe_q);
    r.fields.charge_limit_ma = current_limit(chg_volt_f, temp_f);
    r.fields.discharge_limit_ma = current_limit(dis_volt_f, temp_f);
    r.fields.average_temp = avg[bdm_pkg::TEMP_W-1:0];
    r.fields.average_valid = avg_valid;
    safe_q = safe_now;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_voltage(int v_min, int v_max);
    int ch, wh, wl, cl;
    ch = thr[bdm_pkg::CFG_VOLT_CRIT_HIGH];
    wh = thr[bdm_pkg::CFG_VOLT_WARN_HIGH];
    wl = thr[bdm_pkg::CFG_VOLT_WARN_LOW];
    cl = thr[bdm_pkg::CFG_VOLT_CRIT_LOW];
    volt_ok_q = (v_max < ch) && (v_min > cl) && ((v_max - v_min) < bdm_pkg::SPREAD_LIMIT_MV);
    if (v_max > ch) chg_volt_f = 0;
    else if (v_max >= wh) chg_volt_f = ramp_q16(ch - v_max, ch - wh + bdm_pkg::VOLT_RES_MV);
    else chg_volt_f = int'(bdm_pkg::Q_ONE);
    if (v_min < cl) dis_volt_f = 0;
    else if (v_min <= wl) dis_volt_f = ramp_q16(v_min - cl, wl - cl + bdm_pkg::VOLT_RES_MV);
    else dis_volt_f = int'(bdm_pkg::Q_ONE);
    record_result(KIND_VOLTAGE, 0, 1'b0);
  endfunction

  function automatic void predict_temperature(int t, bit present, bit last);
    int ch, wh, wl, cl, missing, avg;
    bit in_range, avg_valid;
    if (grp_seen < bdm_pkg::MAX_SENSORS) begin
      grp_seen++;
      if (present) begin
        if (!grp_any) begin
          grp_min = t;
          grp_max = t;
        end else begin
          if (t > grp_max) grp_max = t;
          if (t < grp_min) grp_min = t;
        end
        grp_any = 1'b1;
        grp_sum += t;
      end else begin
        grp_missing++;
      end
    end
    if (!last) return;
    ch = thr[bdm_pkg::CFG_TEMP_CRIT_HIGH];
    wh = thr[bdm_pkg::CFG_TEMP_WARN_HIGH];
    wl = thr[bdm_pkg::CFG_TEMP_WARN_LOW];
    cl = thr[bdm_pkg::CFG_TEMP_CRIT_LOW];
    missing = grp_missing + (bdm_pkg::MAX_SENSORS - grp_seen);
    in_range = grp_any && (grp_max < ch) && (grp_min > cl);
    temp_ok_q = in_range && (missing <= bdm_pkg::MAX_MISSING);
    if (!in_range) temp_f = 0;
    else if (grp_max >= wh) temp_f = ramp_q16(ch - grp_max, ch - wh + bdm_pkg::TEMP_RES_DC);
    else if (grp_min <= wl) temp_f = ramp_q16(grp_min - cl, wl - cl + bdm_pkg::TEMP_RES_DC);
    else temp_f = int'(bdm_pkg::Q_ONE);
    avg = 0;
    avg_valid = 1'b0;
    if (grp_any) begin
      avg = grp_sum / (grp_seen - grp_missing);
      avg_valid = 1'b1;
    end
    grp_min = 0;
    grp_max = 0;
    grp_sum = 0;
    grp_missing = 0;
    grp_seen = 0;
    grp_any = 1'b0;
    record_result(KIND_TEMPERATURE, avg, avg_valid);
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    pack_result_t oldest;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer arrived with no result outstanding");
        err_count++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("source_kind", oldest.kind, m_axis_tuser);
        check_field("voltages_ok", oldest.fields.voltages_ok, m_axis_tdata.voltages_ok);
        check_field("temperatures_ok", oldest.fields.temperatures_ok,
                    m_axis_tdata.temperatures_ok);
        check_field("safe_to_operate", oldest.fields.safe_to_operate,
                    m_axis_tdata.safe_to_operate);
        check_field("safe_changed", oldest.fields.safe_changed, m_axis_tdata.safe_changed);
        check_field("charge_limit_ma", oldest.fields.charge_limit_ma,
                    m_axis_tdata.charge_limit_ma);
        check_field("discharge_limit_ma", oldest.fields.discharge_limit_ma,
                    m_axis_tdata.discharge_limit_ma);
        check_field("average_temp", oldest.fields.average_temp, m_axis_tdata.average_temp);
        check_field("average_valid", oldest.fields.average_valid, m_axis_tdata.average_valid);
      end
    end
  end

  // Mostly back-to-back or short gaps, a few long ones, and occasional gap-free bursts.
  function automatic int pick_gap();
    int r;
    if (send_burst > 0) begin
      send_burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      send_burst = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int near_value(int center, int spread, int lo, int hi);
    int v;
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int any_temp();
    return int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
  endfunction

  task automatic send_item(input bit kind, input int v_min, input int v_max, input int t,
                           input bit present, input bit last);
    int gap;
    bdm_pkg::in_data_t d;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    d = '0;
    d.cell_min_mv = v_min[bdm_pkg::VOLT_W-1:0];
    d.cell_max_mv = v_max[bdm_pkg::VOLT_W-1:0];
    d.sensor_temp = t[bdm_pkg::TEMP_W-1:0];
    d.sensor_present = present;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tuser <= kind;
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (kind == KIND_VOLTAGE) predict_voltage(v_min, v_max);
    else predict_temperature(t, present, last);
  endtask

  task automatic send_voltage(input int v_min, input int v_max);
    send_item(KIND_VOLTAGE, v_min, v_max, 0, 1'b0, 1'b0);
  endtask

  task automatic send_sensor(input int t, input bit present, input bit last);
    send_item(KIND_TEMPERATURE, 0, 0, t, present, last);
  endtask

  task automatic wait_for_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [bdm_pkg::IDX_W-1:0] idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[bdm_pkg::VOLT_W-1:0];
    @(posedge clk);
    if (idx < bdm_pkg::CFG_TEMP_CRIT_HIGH) thr[idx] = value & 'h1FFF;
    else thr[idx] = int'($signed(value[bdm_pkg::TEMP_W-1:0]));
  endtask

  task automatic set_thresholds(input int vch, input int vwh, input int vwl, input int vcl,
                                input int tch, input int twh, input int twl, input int tcl);
    write_threshold(bdm_pkg::CFG_VOLT_CRIT_HIGH, vch);
    write_threshold(bdm_pkg::CFG_VOLT_WARN_HIGH, vwh);
    write_threshold(bdm_pkg::CFG_VOLT_WARN_LOW, vwl);
    write_threshold(bdm_pkg::CFG_VOLT_CRIT_LOW, vcl);
    write_threshold(bdm_pkg::CFG_TEMP_CRIT_HIGH, tch);
    write_threshold(bdm_pkg::CFG_TEMP_WARN_HIGH, twh);
    write_threshold(bdm_pkg::CFG_TEMP_WARN_LOW, twl);
    write_threshold(bdm_pkg::CFG_TEMP_CRIT_LOW, tcl);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_thresholds(input int mode);
    int vcl, vwl, vwh, vch, tcl, twl, twh, tch;
    case (mode)
      THR_ALL_LOW: begin
        vcl = 0; vwl = 0; vwh = 0; vch = 0;
        tcl = TEMP_MIN; twl = TEMP_MIN; twh = TEMP_MIN; tch = TEMP_MIN;
      end
      THR_ALL_HIGH: begin
        vcl = VOLT_MAX; vwl = VOLT_MAX; vwh = VOLT_MAX; vch = VOLT_MAX;
        tcl = TEMP_MAX; twl = TEMP_MAX; twh = TEMP_MAX; tch = TEMP_MAX;
      end
      THR_SCRAMBLED: begin
        vcl = $urandom_range(0, VOLT_MAX);
        vwl = $urandom_range(0, VOLT_MAX);
        vwh = $urandom_range(0, VOLT_MAX);
        vch = $urandom_range(0, VOLT_MAX);
        tcl = any_temp();
        twl = any_temp();
        twh = any_temp();
        tch = any_temp();
      end
      default: begin
        vcl = $urandom_range(0, 3000);
        vwl = vcl + $urandom_range(0, 600);
        vwh = vwl + $urandom_range(0, 600);
        vch = vwh + $urandom_range(0, 300);
        tcl = near_value(100, 500, TEMP_MIN, 600);
        twl = tcl + $urandom_range(0, 200);
        twh = twl + $urandom_range(0, 300);
        tch = twh + $urandom_range(0, 200);
      end
    endcase
    set_thresholds(vch, vwh, vwl, vcl, tch, twh, twl, tcl);
  endtask

  task automatic send_random_voltage();
    int lo, hi;
    if ($urandom_range(0, 9) == 0) lo = $urandom_range(0, VOLT_MAX);
    else lo = near_value(thr[bdm_pkg::CFG_VOLT_CRIT_HIGH + $urandom_range(0, 3)], 60, 0,
                         VOLT_MAX);
    if ($urandom_range(0, 9) == 0) hi = $urandom_range(0, VOLT_MAX);
    else hi = near_value(lo + 75, 75, 0, VOLT_MAX);
    send_item(KIND_VOLTAGE, lo, hi, any_temp(), $urandom_range(0, 1),
              $urandom_range(0, 3) == 0);
  endtask

  // One sensor group: mostly full groups, some short ones and some with surplus sensors.
  task automatic send_random_group(output int count);
    int len, base, r, t, absent_odds;
    r = $urandom_range(0, 99);
    if (r < 70) len = bdm_pkg::MAX_SENSORS;
    else if (r < 85) len = $urandom_range(1, bdm_pkg::MAX_SENSORS - 1);
    else len = $urandom_range(bdm_pkg::MAX_SENSORS + 1, bdm_pkg::MAX_SENSORS + 3);
    absent_odds = ($urandom_range(0, 9) == 0) ? 1 : 7;
    base = near_value(thr[bdm_pkg::CFG_TEMP_CRIT_HIGH + $urandom_range(0, 3)], 40, TEMP_MIN,
                      TEMP_MAX);
    for (int i = 0; i < len; i++) begin
      t = ($urandom_range(0, 19) == 0) ? any_temp() : near_value(base, 25, TEMP_MIN, TEMP_MAX);
      send_item(KIND_TEMPERATURE, $urandom_range(0, VOLT_MAX), $urandom_range(0, VOLT_MAX), t,
                $urandom_range(0, absent_odds) != 0, i == len - 1);
    end
    count = len;
  endtask

  task automatic test_reset_defaults();
    send_voltage(3700, 3750);
    send_sensor(250, 1'b1, 1'b0);
    send_sensor(0, 1'b0, 1'b0);
    send_sensor(300, 1'b1, 1'b0);
    send_sensor(350, 1'b1, 1'b1);
  endtask

  task automatic test_voltage_corners();
    send_voltage(0, VOLT_MAX);
    send_voltage(VOLT_MAX, VOLT_MAX);
    send_voltage(3800, 3900);
    send_voltage(3800, 3899);
    send_voltage(4125, 4125);
    send_voltage(3100, 3150);
  endtask

  task automatic test_temperature_groups();
    send_sensor(TEMP_MIN, 1'b1, 1'b0);
    send_sensor(TEMP_MAX, 1'b1, 1'b1);
    send_sensor(200, 1'b0, 1'b1);
    send_sensor(450, 1'b1, 1'b0);
    send_sensor(460, 1'b1, 1'b0);
    send_sensor(470, 1'b1, 1'b0);
    send_sensor(480, 1'b1, 1'b0);
    send_sensor(TEMP_MIN, 1'b1, 1'b1);
  endtask

  task automatic test_inverted_limits();
    wait_for_idle();
    set_thresholds(4000, 4100, 3000, 3300, 300, 400, 20, 50);
    send_voltage(4050, 4050);
    send_sensor(350, 1'b1, 1'b1);
  endtask

  task automatic test_random_traffic();
    int sent, phase_end, mode, count;
    sent = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_for_idle();
      case (phase)
        1: mode = THR_ALL_HIGH;
        3: mode = THR_ALL_LOW;
        4: mode = THR_SCRAMBLED;
        default: mode = THR_ORDERED;
      endcase
      apply_thresholds(mode);
      phase_end = (phase + 1) * RANDOM_ITEMS / PHASES;
      while (sent < phase_end) begin
        if ($urandom_range(0, 99) < 40) begin
          send_random_voltage();
          sent++;
        end else begin
          send_random_group(count);
          sent += count;
        end
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_voltage_corners();
    test_temperature_groups();
    test_inverted_limits();
    test_random_traffic();
    wait_for_idle();
    if (err_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
